@@ rtl/sspr_pkg.sv @@
// Package for the servo status packet receiver.
// Holds the item and result word types, phase enum, codes and reset values.
// No dependencies; every rtl file refers to it by scoped names.
package sspr_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_BYTE  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;

	// Final status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_WRONG_ID = 3'd2;
	localparam logic [2:0] ST_LEN_SHORT = 3'd3;
	localparam logic [2:0] ST_COUNT_MISMATCH = 3'd4;
	localparam logic [2:0] ST_BAD_CHECKSUM = 3'd5;
	localparam logic [2:0] ST_DEVICE_ERROR = 3'd6;

	// Configuration register indexes.
	localparam logic REG_HEADER_BYTE = 1'b0;
	localparam logic REG_TICK_LIMIT  = 1'b1;

	// Register reset values.
	localparam logic [7:0]  HEADER_BYTE_RESET = 8'h55;
	localparam logic [15:0] TICK_LIMIT_RESET  = 16'd50;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_HUNT2 = 3'd2,
		PH_ID    = 3'd3,
		PH_LEN   = 3'd4,
		PH_ERR   = 3'd5,
		PH_PARAM = 3'd6,
		PH_SUM   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] byte_value;
		logic [7:0] servo_id;
		logic [7:0] expected_count;
	} item_t;

	typedef struct packed {
		logic       is_final;
		logic [7:0] param_index;
		logic [7:0] param_byte;
		logic [2:0] status;
		logic [7:0] device_error;
	} result_t;

endpackage

@@ rtl/sspr_in_reg.sv @@
// Input stage of the servo status packet receiver.
// Registers one accepted input word and holds it until the parser takes it.
// Depends on sspr_pkg.
module sspr_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sspr_pkg::item_t in_item,
	input  logic           advance,
	output logic           item_valid,
	output sspr_pkg::item_t item
);

	logic            valid_s1;
	sspr_pkg::item_t item_s1;

	// The stage can refill in the same cycle that its word moves on.
	assign in_stall   = valid_s1 && !advance;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ rtl/sspr_parser.sv @@
// Packet parser of the servo status packet receiver.
// Holds the reception state and works out the result of one word per cycle while its word advances.
// Depends on sspr_pkg.
module sspr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  sspr_pkg::item_t   item,
	input  logic [7:0]        header_byte,
	input  logic [15:0]       tick_limit,
	output logic              res_valid,
	output sspr_pkg::result_t res
);

	sspr_pkg::phase_t phase_q, phase_d;
	logic [7:0]  want_id_q, want_id_d;
	logic [7:0]  want_count_q, want_count_d;
	logic [7:0]  got_id_q, got_id_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  error_byte_q, error_byte_d;
	logic [7:0]  byte_count_q, byte_count_d;
	logic [15:0] time_left_q, time_left_d;

	logic       emit_final;
	logic       emit_param;
	logic [2:0] final_status;
	logic [7:0] len_minus2;
	logic [7:0] count_inc;
	logic       active;

	assign len_minus2 = item.byte_value - 8'd2;
	assign count_inc  = byte_count_q + 8'd1;
	assign active     = (phase_q != sspr_pkg::PH_IDLE);

	// Next state and the kind of result this word causes.
	always_comb begin
		phase_d      = phase_q;
		want_id_d    = want_id_q;
		want_count_d = want_count_q;
		got_id_d     = got_id_q;
		sum_d        = sum_q;
		error_byte_d = error_byte_q;
		byte_count_d = byte_count_q;
		time_left_d  = time_left_q;
		emit_final   = 1'b0;
		emit_param   = 1'b0;
		final_status = sspr_pkg::ST_OK;
		if (advance) begin
			if (item.kind == sspr_pkg::KIND_START) begin
				want_id_d    = item.servo_id;
				want_count_d = item.expected_count;
				got_id_d     = 8'd0;
				sum_d        = 8'd0;
				error_byte_d = 8'd0;
				byte_count_d = 8'd0;
				time_left_d  = tick_limit;
				phase_d      = sspr_pkg::PH_HUNT1;
			end else if (active && item.kind == sspr_pkg::KIND_TICK) begin
				// A zero timeout behaves as a single tick.
				if (time_left_q <= 16'd1) begin
					time_left_d  = 16'd0;
					emit_final   = 1'b1;
					final_status = sspr_pkg::ST_TIMEOUT;
				end else begin
					time_left_d = time_left_q - 16'd1;
				end
			end else if (active && item.kind == sspr_pkg::KIND_BYTE) begin
				unique case (phase_q)
					sspr_pkg::PH_HUNT1: begin
						if (item.byte_value == header_byte) begin
							phase_d = sspr_pkg::PH_HUNT2;
						end
					end
					sspr_pkg::PH_HUNT2: begin
						phase_d = (item.byte_value == header_byte) ?
							sspr_pkg::PH_ID : sspr_pkg::PH_HUNT1;
					end
					sspr_pkg::PH_ID: begin
						got_id_d = item.byte_value;
						phase_d  = sspr_pkg::PH_LEN;
					end
					sspr_pkg::PH_LEN: begin
						if (got_id_q != want_id_q) begin
							emit_final   = 1'b1;
							final_status = sspr_pkg::ST_WRONG_ID;
						end else if (item.byte_value < 8'd2) begin
							emit_final   = 1'b1;
							final_status = sspr_pkg::ST_LEN_SHORT;
						end else if (len_minus2 != want_count_q) begin
							emit_final   = 1'b1;
							final_status = sspr_pkg::ST_COUNT_MISMATCH;
						end else begin
							sum_d   = got_id_q + item.byte_value;
							phase_d = sspr_pkg::PH_ERR;
						end
					end
					sspr_pkg::PH_ERR: begin
						error_byte_d = item.byte_value;
						sum_d        = sum_q + item.byte_value;
						byte_count_d = 8'd0;
						phase_d      = (want_count_q == 8'd0) ?
							sspr_pkg::PH_SUM : sspr_pkg::PH_PARAM;
					end
					sspr_pkg::PH_PARAM: begin
						emit_param   = 1'b1;
						sum_d        = sum_q + item.byte_value;
						byte_count_d = count_inc;
						if (count_inc >= want_count_q) begin
							phase_d = sspr_pkg::PH_SUM;
						end
					end
					sspr_pkg::PH_SUM: begin
						emit_final = 1'b1;
						if (item.byte_value != ~sum_q) begin
							final_status = sspr_pkg::ST_BAD_CHECKSUM;
						end else if (error_byte_q != 8'd0) begin
							final_status = sspr_pkg::ST_DEVICE_ERROR;
						end else begin
							final_status = sspr_pkg::ST_OK;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
			if (emit_final) begin
				phase_d = sspr_pkg::PH_IDLE;
			end
		end
	end

	// Result word.
	always_comb begin
		res_valid = emit_final || emit_param;
		res       = '0;
		if (emit_final) begin
			res.is_final     = 1'b1;
			res.status       = final_status;
			res.device_error = error_byte_q;
		end else if (emit_param) begin
			res.param_index = byte_count_q;
			res.param_byte  = item.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sspr_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Everything below is only read after a start word has loaded it.
	always_ff @(posedge clk) begin
		want_id_q    <= want_id_d;
		want_count_q <= want_count_d;
		got_id_q     <= got_id_d;
		sum_q        <= sum_d;
		error_byte_q <= error_byte_d;
		byte_count_q <= byte_count_d;
		time_left_q  <= time_left_d;
	end

	a_param_only_in_param_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.is_final) |-> (phase_q == sspr_pkg::PH_PARAM))
		else $error("parameter word produced outside the parameter phase");

	a_final_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.is_final) |=> (phase_q == sspr_pkg::PH_IDLE))
		else $error("final status did not end reception");

	a_start_arms_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item.kind == sspr_pkg::KIND_START) |=>
		(phase_q == sspr_pkg::PH_HUNT1 && byte_count_q == 8'd0))
		else $error("start word did not arm the header hunt");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sspr_pkg::PH_IDLE) |-> !res_valid)
		else $error("result produced while idle");

endmodule

@@ rtl/sspr_out_reg.sv @@
// Output stage of the servo status packet receiver.
// Result register that holds a word until the receiver takes it.
// Depends on sspr_pkg.
module sspr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              res_valid,
	input  sspr_pkg::result_t res,
	output logic              out_valid,
	input  logic              out_stall,
	output sspr_pkg::result_t out_res
);

	logic              valid_q;
	sspr_pkg::result_t res_q;

	assign out_valid = valid_q;
	assign out_res   = res_q;

	// The parser only advances when this register is empty or being emptied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res_valid;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

endmodule

@@ rtl/servo_status_packet_receiver_core.sv @@
// Top level of the servo status packet receiver.
// Holds the configuration registers and joins input stage, parser and output stage.
// Depends on sspr_pkg, sspr_in_reg, sspr_parser and sspr_out_reg.
//
// The input channel (in_valid, in_stall) carries one word per handshake. A start
// word (kind 0) arms reception with the servo id and parameter count and loads
// the timeout; byte words (kind 1) feed the serial stream; tick words (kind 2)
// count the millisecond timeout down. The output channel (out_valid, out_stall)
// returns one word per parameter byte and one final status word per packet.
// Words that cause no result (header, id and error bytes, a length byte that passes
// its checks, ticks before the timeout, anything while idle) are absorbed silently.
// Each word is registered in the input register and its result in the output register.
// One word is taken per cycle while the output side is not stalled. With a
// full, stalled result register the input register still takes one more word
// before in_stall rises.
// Reset (arst_n low) empties both registers, returns the parser to idle and loads
// header byte 0x55 and a 50 tick timeout. The configuration port writes
// header_byte (index 0) or tick_limit (index 1) on any cycle with cfg_we high;
// it is meant to be used while no packet is in progress.
module servo_status_packet_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  servo_id,
	input  logic [7:0]  expected_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_final,
	output logic [7:0]  param_index,
	output logic [7:0]  param_byte,
	output logic [2:0]  status,
	output logic [7:0]  device_error,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  header_byte_q;
	logic [15:0] tick_limit_q;

	sspr_pkg::item_t   in_item;
	sspr_pkg::item_t   item;
	sspr_pkg::result_t res;
	sspr_pkg::result_t out_res;
	logic              item_valid;
	logic              res_valid;
	logic              advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= sspr_pkg::HEADER_BYTE_RESET;
			tick_limit_q  <= sspr_pkg::TICK_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sspr_pkg::REG_HEADER_BYTE: header_byte_q <= cfg_data[7:0];
				sspr_pkg::REG_TICK_LIMIT:  tick_limit_q  <= cfg_data;
				default: header_byte_q <= header_byte_q;
			endcase
		end
	end

	assign in_item.kind           = kind;
	assign in_item.byte_value     = byte_value;
	assign in_item.servo_id       = servo_id;
	assign in_item.expected_count = expected_count;

	// The held word moves through the parser whenever the result register can
	// take whatever it produces.
	assign advance = item_valid && (!out_valid || !out_stall);

	sspr_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	sspr_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item),
		.header_byte (header_byte_q),
		.tick_limit  (tick_limit_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	sspr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign is_final     = out_res.is_final;
	assign param_index  = out_res.param_index;
	assign param_byte   = out_res.param_byte;
	assign status       = out_res.status;
	assign device_error = out_res.device_error;

endmodule
